### rtl/frame_classify_steer_assert.svh
// Assertion macros used by the checker file.
`ifndef FRAME_CLASSIFY_STEER_ASSERT_SVH
`define FRAME_CLASSIFY_STEER_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define FCS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also covers the reset cycles.
`define FCS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

### rtl/fcs_pkg.sv
package fcs_pkg;

  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [7:0]  IP_MIN_END     = 8'd34;
  localparam logic [7:0]  TCP_HDR_MIN    = 8'd4;
  localparam logic [6:0]  PORT_SCAN_FROM = 7'd16;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;
  localparam logic [7:0]  IHL_MASK       = 8'h0F;
  localparam logic [15:0] MAC_SIG_RST    = 16'h3607;
  localparam logic [15:0] TCP_PORT_RST   = 16'd443;

  // byte offsets inside the frame
  localparam logic [6:0] POS_SRC2  = 7'd6;
  localparam logic [6:0] POS_SRC3  = 7'd7;
  localparam logic [6:0] POS_SRC4  = 7'd8;
  localparam logic [6:0] POS_SRC5  = 7'd9;
  localparam logic [6:0] POS_ETY_H = 7'd12;
  localparam logic [6:0] POS_ETY_L = 7'd13;
  localparam logic [6:0] POS_VIHL  = 7'd14;
  localparam logic [6:0] POS_PROTO = 7'd23;
  localparam logic [6:0] POS_MAX   = 7'd127;

  typedef enum logic [1:0] {
    CFG_MAC_SIG  = 2'd0,
    CFG_TCP_PORT = 2'd1,
    CFG_SOCKET   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    RSN_REDIRECT  = 4'd0,
    RSN_SHORT_ETH = 4'd1,
    RSN_SIG       = 4'd2,
    RSN_ETHERTYPE = 4'd3,
    RSN_SHORT_IP  = 4'd4,
    RSN_VERSION   = 4'd5,
    RSN_PROTO     = 4'd6,
    RSN_SHORT_TCP = 4'd7,
    RSN_PORT      = 4'd8,
    RSN_NO_SOCKET = 4'd9
  } reason_t;

  typedef struct packed {
    logic [15:0] mac_signature;
    logic [15:0] tcp_port_match;
    logic        socket_bound;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  sig_hi;
    logic [7:0]  sig_lo;
    logic [15:0] ether_type;
    logic [7:0]  version_ihl;
    logic [7:0]  ip_protocol;
    logic [15:0] l4_port;
  } hdr_t;

  typedef struct packed {
    logic total;
    logic tcp;
    logic udp;
    logic redir;
  } bump_t;

endpackage

### rtl/fcs_cfg_regs.sv
module fcs_cfg_regs import fcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_MAC_SIG:  cfg_nxt.mac_signature  = wr_data;
        CFG_TCP_PORT: cfg_nxt.tcp_port_match = wr_data;
        CFG_SOCKET:   cfg_nxt.socket_bound   = wr_data[0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mac_signature  <= MAC_SIG_RST;
      cfg_r.tcp_port_match <= TCP_PORT_RST;
      cfg_r.socket_bound   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/fcs_capture.sv
module fcs_capture import fcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic [6:0] pos,
  output hdr_t       hdr_nxt
);

  hdr_t       hdr_r;
  logic [6:0] pos_r;
  logic [7:0] t_off;

  always_comb begin
    hdr_nxt = hdr_r;
    t_off   = ETH_HDR_LEN + ((hdr_r.version_ihl & IHL_MASK) << 2);
    unique case (pos_r)
      POS_SRC2:  hdr_nxt.sig_hi = byte_i;
      POS_SRC3:  hdr_nxt.sig_lo = byte_i;
      POS_SRC4:  hdr_nxt.sig_hi = hdr_r.sig_hi ^ byte_i;
      POS_SRC5:  hdr_nxt.sig_lo = hdr_r.sig_lo ^ byte_i;
      POS_ETY_H: hdr_nxt.ether_type = {byte_i, 8'h00};
      POS_ETY_L: hdr_nxt.ether_type = {hdr_r.ether_type[15:8], byte_i};
      POS_VIHL:  hdr_nxt.version_ihl = byte_i;
      POS_PROTO: hdr_nxt.ip_protocol = byte_i;
      default: ;
    endcase
    // port bytes sit at T+2/T+3; IHL comes from the stored header byte
    if (pos_r >= PORT_SCAN_FROM) begin
      if ({1'b0, pos_r} == t_off + 8'd2) begin
        hdr_nxt.l4_port = {byte_i, hdr_r.l4_port[7:0]};
      end else if ({1'b0, pos_r} == t_off + 8'd3) begin
        hdr_nxt.l4_port = {hdr_r.l4_port[15:8], byte_i};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
      pos_r <= '0;
    end else if (step) begin
      if (last_i) begin
        hdr_r <= '0;
        pos_r <= '0;
      end else begin
        hdr_r <= hdr_nxt;
        if (pos_r != POS_MAX) begin
          pos_r <= pos_r + 7'd1;
        end
      end
    end
  end

  assign pos = pos_r;

endmodule

### rtl/fcs_classify.sv
module fcs_classify import fcs_pkg::*; (
  input  logic [6:0] pos,
  input  hdr_t       hdr,
  input  cfg_t       cfg,
  output reason_t    reason
);

  logic [7:0] len;
  logic [7:0] t_off;

  always_comb begin
    len   = {1'b0, pos} + 8'd1;
    t_off = ETH_HDR_LEN + ((hdr.version_ihl & IHL_MASK) << 2);
    priority if (len < ETH_HDR_LEN) begin
      reason = RSN_SHORT_ETH;
    end else if ({hdr.sig_hi, hdr.sig_lo} != cfg.mac_signature) begin
      reason = RSN_SIG;
    end else if (hdr.ether_type != ETHERTYPE_IPV4) begin
      reason = RSN_ETHERTYPE;
    end else if (len < IP_MIN_END) begin
      reason = RSN_SHORT_IP;
    end else if (hdr.version_ihl[7:4] != IP_VERSION4) begin
      reason = RSN_VERSION;
    end else if (hdr.ip_protocol != PROTO_TCP && hdr.ip_protocol != PROTO_UDP) begin
      reason = RSN_PROTO;
    end else if (hdr.ip_protocol == PROTO_TCP && len < t_off + TCP_HDR_MIN) begin
      reason = RSN_SHORT_TCP;
    end else if (hdr.ip_protocol == PROTO_TCP && hdr.l4_port != cfg.tcp_port_match) begin
      reason = RSN_PORT;
    end else begin
      reason = RSN_REDIRECT;
    end
  end

endmodule

### rtl/fcs_stats.sv
module fcs_stats import fcs_pkg::*; #(
  parameter int COUNTER_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bump_t                   bump,
  output logic [COUNTER_BITS-1:0] total_nxt,
  output logic [COUNTER_BITS-1:0] tcp_nxt,
  output logic [COUNTER_BITS-1:0] udp_nxt,
  output logic [COUNTER_BITS-1:0] redir_nxt
);

  logic [COUNTER_BITS-1:0] total_r, tcp_r, udp_r, redir_r;

  // values after this frame's increments, wrapping at full width
  assign total_nxt = total_r + COUNTER_BITS'(bump.total);
  assign tcp_nxt   = tcp_r   + COUNTER_BITS'(bump.tcp);
  assign udp_nxt   = udp_r   + COUNTER_BITS'(bump.udp);
  assign redir_nxt = redir_r + COUNTER_BITS'(bump.redir);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      tcp_r   <= '0;
      udp_r   <= '0;
      redir_r <= '0;
    end else begin
      total_r <= total_nxt;
      tcp_r   <= tcp_nxt;
      udp_r   <= udp_nxt;
      redir_r <= redir_nxt;
    end
  end

endmodule

### rtl/frame_classify_steer.sv
// Byte-serial Ethernet frame classifier with a steering verdict.
// in_*  : one frame byte per request, in_tlast on the final byte.
// out_* : one verdict per frame, issued for the byte carrying in_tlast.
// cfg_* : register writes by index (0 MAC signature, 1 TCP port, 2 socket
//         bound); cfg_ready is always high, unmapped indexes are dropped.
// Each byte is registered on entry, then the header capture, the filter chain
// and the counter update run combinationally into the output register, so the
// verdict is registered there as the last byte leaves the entry register.
// Throughput is one byte per cycle, but a final byte waits in the entry
// register while the output register holds a verdict not yet taken.
// A stalled receiver holds the verdict in the output register while further
// non-final bytes keep flowing; a second final byte waits in the entry stage
// until the pending verdict is taken.
// Reset (rst_n low, synchronous) clears the byte position, captured header
// fields, all four counters and both stages, and reloads register defaults.
module frame_classify_steer import fcs_pkg::*; #(
  parameter int COUNTER_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] frame_byte
  input  logic                in_tlast,   // last_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  // [0] steer, [4:1] reason_code, then total_frames, tcp_frames, udp_frames,
  // redirected_frames at COUNTER_BITS each, zero padded to whole bytes
  output logic [((5 + 4 * COUNTER_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int TDATA_W = ((5 + 4 * COUNTER_BITS + 7) / 8) * 8;
  localparam int CNT0_LO = 5;

  logic                s1_valid_r, s1_valid_nxt;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  logic                s1_adv;
  logic                out_valid_r, out_valid_nxt;
  logic [TDATA_W-1:0]  out_data_r, out_data_nxt;

  cfg_t                cfg;
  hdr_t                hdr_nxt;
  logic [6:0]          pos;
  reason_t             rsn_cls, rsn_fin;
  logic                pass;
  bump_t               bump;
  logic [COUNTER_BITS-1:0] total_nxt, tcp_nxt, udp_nxt, redir_nxt;

  assign cfg_ready = 1'b1;

  fcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // a final byte moves on only when the output register is free
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  fcs_capture u_cap (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .byte_i  (s1_byte_r),
    .last_i  (s1_last_r),
    .pos     (pos),
    .hdr_nxt (hdr_nxt)
  );

  fcs_classify u_cls (
    .pos    (pos),
    .hdr    (hdr_nxt),
    .cfg    (cfg),
    .reason (rsn_cls)
  );

  always_comb begin
    pass       = (rsn_cls == RSN_REDIRECT);
    bump.total = s1_adv && s1_last_r;
    bump.tcp   = bump.total && pass && (hdr_nxt.ip_protocol == PROTO_TCP);
    bump.udp   = bump.total && pass && (hdr_nxt.ip_protocol != PROTO_TCP);
    bump.redir = bump.total && pass && cfg.socket_bound;
    rsn_fin    = (pass && !cfg.socket_bound) ? RSN_NO_SOCKET : rsn_cls;
  end

  fcs_stats #(.COUNTER_BITS(COUNTER_BITS)) u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .bump      (bump),
    .total_nxt (total_nxt),
    .tcp_nxt   (tcp_nxt),
    .udp_nxt   (udp_nxt),
    .redir_nxt (redir_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end

    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (bump.total) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[0]   = pass && cfg.socket_bound;
      out_data_nxt[4:1] = rsn_fin;
      out_data_nxt[CNT0_LO                    +: COUNTER_BITS] = total_nxt;
      out_data_nxt[CNT0_LO + COUNTER_BITS     +: COUNTER_BITS] = tcp_nxt;
      out_data_nxt[CNT0_LO + 2 * COUNTER_BITS +: COUNTER_BITS] = udp_nxt;
      out_data_nxt[CNT0_LO + 3 * COUNTER_BITS +: COUNTER_BITS] = redir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/fcs_checker.sv
`include "frame_classify_steer_assert.svh"

module fcs_checker import fcs_pkg::*; #(
  parameter int COUNTER_BITS = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [((5 + 4 * COUNTER_BITS + 7) / 8) * 8 - 1:0] out_tdata
);

  // a stalled verdict stays put
  `FCS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // steer is set exactly for the redirected code
  `FCS_ASSERT(a_steer_code, clk, rst_n, out_tvalid |-> (out_tdata[0] == (out_tdata[4:1] == RSN_REDIRECT)))

  // no code above no-socket is ever produced
  `FCS_ASSERT(a_code_range, clk, rst_n, out_tvalid |-> (out_tdata[4:1] <= RSN_NO_SOCKET))

  // reset empties the output stage
  `FCS_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid)

endmodule

bind frame_classify_steer fcs_checker #(.COUNTER_BITS(COUNTER_BITS)) u_fcs_checker (.*);
